// ----- rtl/core/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and codes of the utf-8 sequence decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int unsigned CP_WIDTH  = 21;
   localparam int unsigned LEN_WIDTH = 3;
   localparam int unsigned ERR_WIDTH = 3;

   // tag of a continuation byte in its top two bits
   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef enum logic [ERR_WIDTH-1:0] {
      ERR_OK        = 3'd0,
      ERR_OVERLONG  = 3'd1,
      ERR_BAD_START = 3'd2,
      ERR_BAD_BYTE2 = 3'd3,
      ERR_BAD_BYTE3 = 3'd4,
      ERR_BAD_BYTE4 = 3'd5
   } err_type;

   // first stage: length, masked lead payload, continuation payloads and tags
   typedef struct packed {
      logic [LEN_WIDTH-1:0] len;
      logic [6:0]           lead;
      logic [5:0]           pay2;
      logic [5:0]           pay3;
      logic [5:0]           pay4;
      logic [2:0]           cont_ok;   // bytes 4,3,2
   } s1_type;

   // second stage: assembled value with the checks still open
   typedef struct packed {
      logic [LEN_WIDTH-1:0] len;
      logic [CP_WIDTH-1:0]  cp;
      logic [2:0]           cont_ok;
   } s2_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0]  cp;
      logic [LEN_WIDTH-1:0] len;
      err_type              err;
   } rsp_type;

endpackage

// ----- rtl/core/utf8_sequence_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_sequence_decoder
// an input transfer passes the decode, assemble and check registers in turn
// to the rsp port; throughput: one sequence per cycle while rsp_ready holds,
// set by the three register stages, each taking a new item when the next moves
// reset: synchronous, clears the stage valid bits only; nothing else is held
// decodes one utf-8 sequence of up to four bytes into a code point, the
// length and an error code
// ----------------------------------------------------------------------------
module utf8_sequence_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_first_byte,
   input  logic [7:0]                          req_second_byte,
   input  logic [7:0]                          req_third_byte,
   input  logic [7:0]                          req_fourth_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utf8d_pkg::CP_WIDTH-1:0]      rsp_code_point,
   output logic [utf8d_pkg::LEN_WIDTH-1:0]     rsp_seq_length,
   output logic [utf8d_pkg::ERR_WIDTH-1:0]     rsp_error_code
);
   import utf8d_pkg::*;

   // stage registers, valid bits travel alongside the data
   s1_type  s1_ff, s1_in;
   logic    s1_v_ff;
   s2_type  s2_ff, s2_in;
   logic    s2_v_ff;
   rsp_type out_ff, out_in;
   logic    out_v_ff;

   // per-stage advance: a stage takes new data when empty or when it moves on
   logic out_ready;
   logic s2_ready;
   logic s1_ready;

   assign out_ready = !out_v_ff || rsp_ready;
   assign s2_ready  = !s2_v_ff  || out_ready;
   assign s1_ready  = !s1_v_ff  || s2_ready;
   assign req_ready = s1_ready;

   // stage one: length lookup, lead mask and continuation tags
   utf8d_front u_front (
      .first_byte  (req_first_byte),
      .second_byte (req_second_byte),
      .third_byte  (req_third_byte),
      .fourth_byte (req_fourth_byte),
      .decoded     (s1_in)
   );

   // stage two: join the payload bits into the value by length
   always_comb begin
      s2_in.len     = s1_ff.len;
      s2_in.cont_ok = s1_ff.cont_ok;
      case (s1_ff.len)
         3'd1:    s2_in.cp = {14'd0, s1_ff.lead};
         3'd2:    s2_in.cp = {10'd0, s1_ff.lead[4:0], s1_ff.pay2};
         3'd3:    s2_in.cp = {5'd0, s1_ff.lead[3:0], s1_ff.pay2, s1_ff.pay3};
         3'd4:    s2_in.cp = {s1_ff.lead[2:0], s1_ff.pay2, s1_ff.pay3, s1_ff.pay4};
         default: s2_in.cp = '0;
      endcase
   end

   // stage three: overlong check and error priority, into the output register
   utf8d_check u_check (
      .assembled (s2_ff),
      .result    (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_ready) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   // payload moves with its stage, no reset needed
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (out_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_code_point = out_ff.cp;
   assign rsp_seq_length = out_ff.len;
   assign rsp_error_code = out_ff.err;

   // a full middle stage held back by a stalled output keeps its item
   assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !s2_ready |=> s2_v_ff)
      else $error("stage two item dropped during a stall");

   // an accepted transfer always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_v_ff)
      else $error("accepted transfer not captured");

   // value cleared whenever an error is reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_OK) |-> (rsp_code_point == '0))
      else $error("code point not cleared on error");

   // zero length goes with a bad start byte and nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_seq_length == '0) == (rsp_error_code == ERR_BAD_START)))
      else $error("length and bad start code disagree");

endmodule

// ----- rtl/core/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// utf8d_front
// start byte decode, lead masking and continuation tag checks
// ----------------------------------------------------------------------------
module utf8d_front (
   input  logic [7:0]        first_byte,
   input  logic [7:0]        second_byte,
   input  logic [7:0]        third_byte,
   input  logic [7:0]        fourth_byte,
   output utf8d_pkg::s1_type decoded
);
   import utf8d_pkg::*;

   logic [LEN_WIDTH-1:0] len;
   logic [6:0]           mask;

   // length from the top five bits of the start byte
   always_comb begin
      case (first_byte[7:3])
         5'b11000, 5'b11001, 5'b11010, 5'b11011: len = 3'd2;
         5'b11100, 5'b11101:                     len = 3'd3;
         5'b11110:                               len = 3'd4;
         default: begin
            if (first_byte[7] == 1'b0) len = 3'd1;
            else                       len = 3'd0;
         end
      endcase
   end

   always_comb begin
      case (len)
         3'd1:    mask = 7'h7f;
         3'd2:    mask = 7'h1f;
         3'd3:    mask = 7'h0f;
         3'd4:    mask = 7'h07;
         default: mask = 7'h00;
      endcase
   end

   always_comb begin
      decoded.len        = len;
      decoded.lead       = first_byte[6:0] & mask;
      decoded.pay2       = second_byte[5:0];
      decoded.pay3       = third_byte[5:0];
      decoded.pay4       = fourth_byte[5:0];
      decoded.cont_ok[0] = (second_byte[7:6] == CONT_TAG);
      decoded.cont_ok[1] = (third_byte[7:6] == CONT_TAG);
      decoded.cont_ok[2] = (fourth_byte[7:6] == CONT_TAG);
   end

endmodule

// ----- rtl/core/utf8d_check.sv -----
// ----------------------------------------------------------------------------
// utf8d_check
// overlong compare, error priority and clearing of the value on error
// ----------------------------------------------------------------------------
module utf8d_check (
   input  utf8d_pkg::s2_type  assembled,
   output utf8d_pkg::rsp_type result
);
   import utf8d_pkg::*;

   logic [CP_WIDTH-1:0] min_value;
   err_type             err;

   // smallest value that needs this many bytes
   always_comb begin
      case (assembled.len)
         3'd2:    min_value = 21'h000080;
         3'd3:    min_value = 21'h000800;
         3'd4:    min_value = 21'h010000;
         default: min_value = '0;
      endcase
   end

   always_comb begin
      if (assembled.len == 3'd0) begin
         err = ERR_BAD_START;
      end else if (assembled.cp < min_value) begin
         err = ERR_OVERLONG;
      end else if (assembled.len >= 3'd2 && !assembled.cont_ok[0]) begin
         err = ERR_BAD_BYTE2;
      end else if (assembled.len >= 3'd3 && !assembled.cont_ok[1]) begin
         err = ERR_BAD_BYTE3;
      end else if (assembled.len >= 3'd4 && !assembled.cont_ok[2]) begin
         err = ERR_BAD_BYTE4;
      end else begin
         err = ERR_OK;
      end
   end

   always_comb begin
      result.len = assembled.len;
      result.err = err;
      result.cp  = (err == ERR_OK) ? assembled.cp : '0;
   end

endmodule
